// ----- hdl/lbcs_pkg.sv -----
// shared types, reset values and the chase pattern table for the lamp sequencer
package lbcs_pkg;

  localparam int unsigned LAMP_COUNT = 4;
  localparam logic [5:0]  LAST_STEP  = 6'd34;

  localparam logic [2:0] REG_PWM_TOP      = 3'd0;
  localparam logic [2:0] REG_BOTTOM_PAUSE = 3'd1;
  localparam logic [2:0] REG_DWELL_FIRST  = 3'd2;
  localparam logic [2:0] REG_DWELL_SECOND = 3'd3;
  localparam logic [2:0] REG_DWELL_THIRD  = 3'd4;
  localparam logic [2:0] REG_DWELL_FOURTH = 3'd5;

  localparam logic [7:0] PWM_TOP_RST      = 8'd243;
  localparam logic [7:0] BOTTOM_PAUSE_RST = 8'd11;
  localparam logic [7:0] DWELL_FIRST_RST  = 8'd100;
  localparam logic [7:0] DWELL_SECOND_RST = 8'd80;
  localparam logic [7:0] DWELL_THIRD_RST  = 8'd60;
  localparam logic [7:0] DWELL_FOURTH_RST = 8'd40;
  localparam logic [7:0] DUTY_RST         = 8'd244;
  localparam logic [7:0] PAUSE_RST        = 8'd14;

  localparam logic [5:0] STEP_SECOND = 6'd17;
  localparam logic [5:0] STEP_FOURTH = 6'd33;

  typedef struct packed {
    logic [1:0] lamp;
    logic       on;
  } lamp_act_t;

  // pattern action for the first tick of a step
  function automatic lamp_act_t chase_action(input logic [5:0] step);
    lamp_act_t act;
    case (step) inside
      6'd0, 6'd6, 6'd12, 6'd18, 6'd26:  act = '{lamp: 2'd3, on: 1'b1};
      6'd1, 6'd7, 6'd13, 6'd19, 6'd27:  act = '{lamp: 2'd2, on: 1'b1};
      6'd2, 6'd8, 6'd14, 6'd20, 6'd28:  act = '{lamp: 2'd1, on: 1'b1};
      6'd3, 6'd9, 6'd15, 6'd23, 6'd31:  act = '{lamp: 2'd1, on: 1'b0};
      6'd4, 6'd10, 6'd16, 6'd24, 6'd32: act = '{lamp: 2'd2, on: 1'b0};
      6'd5, 6'd11, 6'd17, 6'd25, 6'd33: act = '{lamp: 2'd3, on: 1'b0};
      6'd21, 6'd29:                     act = '{lamp: 2'd0, on: 1'b1};
      6'd22, 6'd30:                     act = '{lamp: 2'd0, on: 1'b0};
      default:                          act = '{lamp: 2'd3, on: 1'b1};
    endcase
    return act;
  endfunction

endpackage

// ----- hdl/lamp_breathing_and_chase_sequencer_top.sv -----
// lamp breathing pwm and four-lamp chase sequencer, one pwm slot per beat
// an accepted input beat gives its result beat in the next cycle
// throughput: one beat per cycle while out_ready is high; the result register is freed as it is taken
// all counters update from the current state in a single combinational pass
// reset (synchronous) loads register and counter reset values at once
// no memories, so no clearing pass after reset
module lamp_breathing_and_chase_sequencer_top
  import lbcs_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       ms_tick,
  output logic       out_valid,
  input  logic       out_ready,
  output logic       pwm_on,
  output logic       lamp_zero_on,
  output logic       lamp_one_on,
  output logic       lamp_two_on,
  output logic       lamp_three_on,
  input  logic       cfg_write,
  input  logic [2:0] cfg_index,
  input  logic [7:0] cfg_data
);

  logic [7:0] pwm_top, bottom_pause;
  logic [7:0] dwell_first, dwell_second, dwell_third, dwell_fourth;

  logic [7:0] slot_count, slot_count_next;
  logic [7:0] duty_level, duty_level_next;
  logic       rising, rising_next;
  logic [7:0] pause_left, pause_left_next;
  logic [7:0] tick_count, tick_count_next;
  logic [5:0] chase_step, chase_step_next;
  logic [7:0] step_dwell, step_dwell_next;
  logic [LAMP_COUNT-1:0] lamp_states, lamp_states_next;
  logic       pwm_next;

  logic       accept;
  logic [8:0] duty_inc;
  logic [8:0] tick_inc;
  logic [6:0] step_inc;
  lamp_act_t  act;

  assign in_ready = !out_valid || out_ready;
  assign accept   = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      pwm_top      <= PWM_TOP_RST;
      bottom_pause <= BOTTOM_PAUSE_RST;
      dwell_first  <= DWELL_FIRST_RST;
      dwell_second <= DWELL_SECOND_RST;
      dwell_third  <= DWELL_THIRD_RST;
      dwell_fourth <= DWELL_FOURTH_RST;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_PWM_TOP:      pwm_top      <= cfg_data;
        REG_BOTTOM_PAUSE: bottom_pause <= cfg_data;
        REG_DWELL_FIRST:  dwell_first  <= cfg_data;
        REG_DWELL_SECOND: dwell_second <= cfg_data;
        REG_DWELL_THIRD:  dwell_third  <= cfg_data;
        REG_DWELL_FOURTH: dwell_fourth <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    pwm_next         = duty_level > slot_count;
    slot_count_next  = (slot_count >= pwm_top) ? 8'd0 : slot_count + 8'd1;
    duty_level_next  = duty_level;
    rising_next      = rising;
    pause_left_next  = pause_left;
    tick_count_next  = tick_count;
    chase_step_next  = chase_step;
    step_dwell_next  = step_dwell;
    lamp_states_next = lamp_states;
    duty_inc         = {1'b0, duty_level} + 9'd1;
    tick_inc         = {1'b0, tick_count} + 9'd1;
    step_inc         = {1'b0, chase_step} + 7'd1;
    act              = chase_action(chase_step);

    if (ms_tick) begin
      // breathing ramp
      if (pause_left != 8'd0) begin
        pause_left_next = pause_left - 8'd1;
      end else if (rising) begin
        if (duty_inc >= {1'b0, pwm_top}) begin
          duty_level_next = pwm_top;
          rising_next     = 1'b0;
        end else begin
          duty_level_next = duty_inc[7:0];
        end
      end else if (duty_level <= 8'd1) begin
        duty_level_next = 8'd0;
        rising_next     = 1'b1;
        pause_left_next = bottom_pause;
      end else begin
        duty_level_next = duty_level - 8'd1;
      end

      // chase
      if (tick_count == 8'd0) begin
        lamp_states_next[act.lamp] = act.on;
      end
      if (tick_inc > {1'b0, step_dwell}) begin
        tick_count_next = 8'd0;
        chase_step_next = (step_inc > {1'b0, LAST_STEP}) ? 6'd0 : step_inc[5:0];
        if (chase_step_next < STEP_SECOND) begin
          step_dwell_next = dwell_first;
        end else if (chase_step_next == STEP_SECOND) begin
          step_dwell_next = dwell_second;
        end else if (chase_step_next < STEP_FOURTH) begin
          step_dwell_next = dwell_third;
        end else if (chase_step_next == STEP_FOURTH) begin
          step_dwell_next = dwell_fourth;
        end
      end else begin
        tick_count_next = tick_inc[7:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_count  <= 8'd0;
      duty_level  <= DUTY_RST;
      rising      <= 1'b0;
      pause_left  <= PAUSE_RST;
      tick_count  <= 8'd0;
      chase_step  <= 6'd0;
      step_dwell  <= DWELL_FIRST_RST;
      lamp_states <= '0;
      out_valid   <= 1'b0;
    end else begin
      if (accept) begin
        slot_count  <= slot_count_next;
        duty_level  <= duty_level_next;
        rising      <= rising_next;
        pause_left  <= pause_left_next;
        tick_count  <= tick_count_next;
        chase_step  <= chase_step_next;
        step_dwell  <= step_dwell_next;
        lamp_states <= lamp_states_next;
        out_valid   <= 1'b1;
      end else if (out_ready) begin
        out_valid   <= 1'b0;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (accept) begin
      pwm_on        <= pwm_next;
      lamp_zero_on  <= lamp_states_next[0];
      lamp_one_on   <= lamp_states_next[1];
      lamp_two_on   <= lamp_states_next[2];
      lamp_three_on <= lamp_states_next[3];
    end
  end

endmodule

// ----- verif/lbcs_lamp_checker.sv -----
// slot predictor and result checker for the lamp breathing and chase sequencer
module lbcs_lamp_checker
  import lbcs_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic              in_ready,
  input  logic              ms_tick,
  input  logic              out_valid,
  input  logic              out_ready,
  input  logic              pwm_on,
  input  logic              lamp_zero_on,
  input  logic              lamp_one_on,
  input  logic              lamp_two_on,
  input  logic              lamp_three_on,
  input  logic              cfg_write,
  input  logic [2:0]        cfg_index,
  input  logic [7:0]        cfg_data,
  output int unsigned       pending,
  output int unsigned       mismatches
);

  typedef struct packed {
    logic       pwm;
    logic [3:0] lamps;
  } lamp_frame_t;

  logic [7:0] cfg_pwm_top;
  logic [7:0] cfg_bottom_pause;
  logic [7:0] cfg_dwell [0:3];

  logic [7:0] slot;
  logic [7:0] duty;
  logic       rising;
  logic [7:0] pause_left;
  logic [7:0] ticks;
  logic [5:0] step;
  logic [7:0] dwell;
  logic [3:0] lamps;

  lamp_frame_t frames_due [$];
  int unsigned errs = 0;

  initial begin
    pending = 0;
    mismatches = 0;
  end

  task automatic predict_slot(input logic tick, output lamp_frame_t frame);
    logic [8:0] next_duty;
    logic [1:0] lamp_idx;
    logic       lamp_on;
    frame.pwm = (duty > slot);
    if (slot >= cfg_pwm_top) slot = 8'd0;
    else slot = slot + 8'd1;
    if (tick) begin
      // triangle ramp
      if (pause_left != 8'd0) begin
        pause_left = pause_left - 8'd1;
      end else if (rising) begin
        next_duty = {1'b0, duty} + 9'd1;
        if (next_duty >= {1'b0, cfg_pwm_top}) begin
          duty = cfg_pwm_top;
          rising = 1'b0;
        end else begin
          duty = next_duty[7:0];
        end
      end else if (duty <= 8'd1) begin
        duty = 8'd0;
        rising = 1'b1;
        pause_left = cfg_bottom_pause;
      end else begin
        duty = duty - 8'd1;
      end
      // chase pattern, applied on the first tick of a step
      if (ticks == 8'd0) begin
        if (step < 6'd18) begin
          case (step % 6)
            0: {lamp_idx, lamp_on} = {2'd3, 1'b1};
            1: {lamp_idx, lamp_on} = {2'd2, 1'b1};
            2: {lamp_idx, lamp_on} = {2'd1, 1'b1};
            3: {lamp_idx, lamp_on} = {2'd1, 1'b0};
            4: {lamp_idx, lamp_on} = {2'd2, 1'b0};
            default: {lamp_idx, lamp_on} = {2'd3, 1'b0};
          endcase
        end else if (step < LAST_STEP) begin
          case ((step - 6'd18) % 8)
            0: {lamp_idx, lamp_on} = {2'd3, 1'b1};
            1: {lamp_idx, lamp_on} = {2'd2, 1'b1};
            2: {lamp_idx, lamp_on} = {2'd1, 1'b1};
            3: {lamp_idx, lamp_on} = {2'd0, 1'b1};
            4: {lamp_idx, lamp_on} = {2'd0, 1'b0};
            5: {lamp_idx, lamp_on} = {2'd1, 1'b0};
            6: {lamp_idx, lamp_on} = {2'd2, 1'b0};
            default: {lamp_idx, lamp_on} = {2'd3, 1'b0};
          endcase
        end else begin
          {lamp_idx, lamp_on} = {2'd3, 1'b1};
        end
        lamps[lamp_idx] = lamp_on;
      end
      if ({1'b0, ticks} + 9'd1 > {1'b0, dwell}) begin
        ticks = 8'd0;
        step = (step >= LAST_STEP) ? 6'd0 : step + 6'd1;
        if (step < STEP_SECOND) dwell = cfg_dwell[0];
        else if (step == STEP_SECOND) dwell = cfg_dwell[1];
        else if (step < STEP_FOURTH) dwell = cfg_dwell[2];
        else if (step == STEP_FOURTH) dwell = cfg_dwell[3];
      end else begin
        ticks = ticks + 8'd1;
      end
    end
    frame.lamps = lamps;
  endtask

  task automatic check_field(input string name, input logic want, input logic got);
    if (want !== got) begin
      $display("%0t: %s expected %b actual %b", $time, name, want, got);
      errs++;
    end
  endtask

  always @(posedge clk) begin
    lamp_frame_t want;
    if (rst) begin
      cfg_pwm_top <= PWM_TOP_RST;
      cfg_bottom_pause <= BOTTOM_PAUSE_RST;
      cfg_dwell[0] <= DWELL_FIRST_RST;
      cfg_dwell[1] <= DWELL_SECOND_RST;
      cfg_dwell[2] <= DWELL_THIRD_RST;
      cfg_dwell[3] <= DWELL_FOURTH_RST;
      slot = 8'd0;
      duty = DUTY_RST;
      rising = 1'b0;
      pause_left = PAUSE_RST;
      ticks = 8'd0;
      step = 6'd0;
      dwell = DWELL_FIRST_RST;
      lamps = 4'd0;
      frames_due.delete();
      pending <= 0;
    end else begin
      if (in_valid && in_ready) begin
        predict_slot(ms_tick, want);
        frames_due.push_back(want);
      end
      if (out_valid && out_ready) begin
        if (frames_due.size() == 0) begin
          $display("%0t: result beat with no slot pending", $time);
          errs++;
        end else begin
          want = frames_due.pop_front();
          check_field("pwm_on", want.pwm, pwm_on);
          check_field("lamp_zero_on", want.lamps[0], lamp_zero_on);
          check_field("lamp_one_on", want.lamps[1], lamp_one_on);
          check_field("lamp_two_on", want.lamps[2], lamp_two_on);
          check_field("lamp_three_on", want.lamps[3], lamp_three_on);
        end
      end
      if (cfg_write) begin
        case (cfg_index)
          REG_PWM_TOP:      cfg_pwm_top <= cfg_data;
          REG_BOTTOM_PAUSE: cfg_bottom_pause <= cfg_data;
          REG_DWELL_FIRST:  cfg_dwell[0] <= cfg_data;
          REG_DWELL_SECOND: cfg_dwell[1] <= cfg_data;
          REG_DWELL_THIRD:  cfg_dwell[2] <= cfg_data;
          REG_DWELL_FOURTH: cfg_dwell[3] <= cfg_data;
          default: ;
        endcase
      end
      pending <= frames_due.size();
    end
    mismatches <= errs;
  end

endmodule

// ----- verif/lamp_breathing_and_chase_sequencer_top_tb.sv -----
// testbench top: clock, reset, slot and register stimulus, and the final verdict
module lamp_breathing_and_chase_sequencer_top_tb;
  import lbcs_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned PHASES      = 7;
  localparam int unsigned PHASE_BEATS = 132;
  localparam logic [2:0]  REG_SPARE_A = 3'd6;
  localparam logic [2:0]  REG_SPARE_B = 3'd7;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic       ms_tick = 1'b0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic       pwm_on;
  logic       lamp_zero_on;
  logic       lamp_one_on;
  logic       lamp_two_on;
  logic       lamp_three_on;
  logic       cfg_write = 1'b0;
  logic [2:0] cfg_index = REG_PWM_TOP;
  logic [7:0] cfg_data = 8'd0;

  logic        steady = 1'b1;
  int unsigned ready_hold = 0;
  int unsigned cycles = 0;
  int unsigned pending;
  int unsigned mismatches;

  lamp_breathing_and_chase_sequencer_top DUT (.*);

  lbcs_lamp_checker checker_i (.*);

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("lamp_breathing_and_chase_sequencer_top_tb: errors");
      $finish;
    end
  end

  function automatic int unsigned gap_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic logic [7:0] pick_value(input int unsigned lo, input int unsigned hi,
                                            input int unsigned near_hi);
    if ($urandom_range(0, 3) != 0) return 8'($urandom_range(lo, near_hi));
    return 8'($urandom_range(lo, hi));
  endfunction

  // result side back-pressure
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
      ready_hold <= 0;
    end else if (steady) begin
      out_ready <= 1'b1;
    end else if (ready_hold != 0) begin
      ready_hold <= ready_hold - 1;
    end else if (out_ready) begin
      out_ready <= 1'b0;
      ready_hold <= gap_len();
    end else begin
      out_ready <= 1'b1;
      ready_hold <= $urandom_range(0, 15);
    end
  end

  task automatic send_slot(input logic tick);
    int unsigned gap;
    in_valid <= 1'b1;
    ms_tick <= tick;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    gap = steady ? 0 : gap_len();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [7:0] value);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
  endtask

  task automatic write_all(input logic [7:0] top, input logic [7:0] pause,
                           input logic [7:0] d0, input logic [7:0] d1,
                           input logic [7:0] d2, input logic [7:0] d3);
    write_reg(REG_PWM_TOP, top);
    write_reg(REG_BOTTOM_PAUSE, pause);
    write_reg(REG_DWELL_FIRST, d0);
    write_reg(REG_DWELL_SECOND, d1);
    write_reg(REG_DWELL_THIRD, d2);
    write_reg(REG_DWELL_FOURTH, d3);
    cfg_write <= 1'b0;
  endtask

  initial begin
    logic [7:0]  at_reset;
    int unsigned tick_pct;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // reset settings, ticks and idle slots mixed
    at_reset = 8'b1001_1010;
    for (int i = 0; i < 8; i++) send_slot(at_reset[i]);
    settle();

    // unused register indexes must be ignored, then the low extremes
    write_reg(REG_SPARE_A, 8'hFF);
    write_reg(REG_SPARE_B, 8'h00);
    write_all(8'd1, 8'd0, 8'd1, 8'd1, 8'd1, 8'd1);
    @(posedge clk);
    for (int i = 0; i < 14; i++) send_slot(1'b1);
    send_slot(1'b0);
    send_slot(1'b0);
    send_slot(1'b1);

    for (int p = 0; p < PHASES; p++) begin
      settle();
      if (p == PHASES - 1) begin
        write_all(8'd254, 8'd255, 8'd254, 8'd254, 8'd254, 8'd254);
        @(posedge clk);
      end else if (p > 0) begin
        write_all(pick_value(1, 254, 12), pick_value(0, 255, 4), pick_value(1, 254, 3),
                  pick_value(1, 254, 3), pick_value(1, 254, 3), pick_value(1, 254, 3));
        @(posedge clk);
      end
      steady <= (p == 3);
      tick_pct = (p == 0) ? 90 : $urandom_range(30, 100);
      for (int n = 0; n < PHASE_BEATS; n++) begin
        if (n == PHASE_BEATS / 2) settle();
        send_slot($urandom_range(0, 99) < tick_pct);
      end
    end

    settle();
    repeat (4) @(posedge clk);
    if (mismatches == 0 && pending == 0)
      $display("lamp_breathing_and_chase_sequencer_top_tb: clean");
    else
      $display("lamp_breathing_and_chase_sequencer_top_tb: errors");
    $finish;
  end

endmodule
